// ----- rtl/wsl_pkg.sv -----
`timescale 1ns / 1ps

package wsl_pkg;

    localparam int COORD_W   = 24;
    localparam int SLOT_W    = 8;
    localparam int ANGLE_W   = 16;
    localparam int TARGET_W  = 9;
    localparam int REACH_W   = 16;
    localparam int LIMIT_W   = 15;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CX_W      = 44;
    localparam int Z_W       = 32;
    localparam int ITER_W    = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAYPOINT_COUNT = 4'd0,
        CFG_REACH_DISTANCE = 4'd1,
        CFG_MAX_STEER_STEP = 4'd2,
        CFG_MAX_STEER      = 4'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MUL_DX = 2'd0,
        MUL_DY = 2'd1,
        MUL_R  = 2'd2
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_R,
        S_CMP,
        S_ADV,
        S_READ2,
        S_DIFF2,
        S_CINIT,
        S_CITER,
        S_DELTA,
        S_STEER,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic [TARGET_W-1:0] waypoint_count;
        logic [REACH_W-1:0]  reach_distance;
        logic [LIMIT_W-1:0]  max_steer_step;
        logic [LIMIT_W-1:0]  max_steer;
    } cfg_t;

    typedef struct packed {
        logic     capture;
        logic     load_wr;
        logic     mem_rd;
        logic     diff;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum_first;
        logic     sum_add;
        logic     target_inc;
        logic     cordic_init;
        logic     cordic_step;
        logic     delta;
        logic     steer;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic target_done;
        logic near;
        logic cordic_last;
        logic out_busy;
    } status_t;

    function automatic logic [Z_W-1:0] atan_unit(input logic [ITER_W-1:0] idx);
        logic [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/wsl_in_if.sv -----
`timescale 1ns / 1ps

interface wsl_in_if;
    import wsl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [SLOT_W-1:0]         waypoint_slot;
    logic signed [COORD_W-1:0] waypoint_x;
    logic signed [COORD_W-1:0] waypoint_y;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [ANGLE_W-1:0] heading;

    modport source (
        output valid, opcode, waypoint_slot, waypoint_x, waypoint_y, pos_x, pos_y, heading,
        input  ready
    );

    modport sink (
        input  valid, opcode, waypoint_slot, waypoint_x, waypoint_y, pos_x, pos_y, heading,
        output ready
    );
endinterface

// ----- rtl/wsl_out_if.sv -----
`timescale 1ns / 1ps

interface wsl_out_if;
    import wsl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] steer_angle;
    logic [TARGET_W-1:0]       target_index;
    logic                      finished;

    modport source (
        output valid, steer_angle, target_index, finished,
        input  ready
    );

    modport sink (
        input  valid, steer_angle, target_index, finished,
        output ready
    );
endinterface

// ----- rtl/wsl_cfg_if.sv -----
`timescale 1ns / 1ps

interface wsl_cfg_if;
    import wsl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- rtl/waypoint_steering_limiter.sv -----
`timescale 1ns / 1ps

// Waypoint steering limiter. Load items write one waypoint into the table and
// return the present steer state via the output register; the table holds
// MAX_WAYPOINTS entries whose contents are undefined until written, so load
// every slot below waypoint_count before stepping. A step item reads the
// target, checks the reach distance with one shared multiplier, runs an
// iterative CORDIC atan2 of CORDIC_STEPS iterations, then applies the rate
// limit and the steer clamp. Within reach, the target advances once to the
// next waypoint, which the step then steers toward; when the advance ends the
// list, or the list is already finished, the step returns the present steer
// state unchanged. The CORDIC iteration sets the step rate. One item is in
// work at a time; a finished result waits in the output register while the
// next item is taken. Configuration writes are accepted every cycle.
module waypoint_steering_limiter #(
    parameter int MAX_WAYPOINTS = 256,
    parameter int CORDIC_STEPS  = 16
) (
    input logic       clk,
    input logic       rst_n,
    wsl_in_if.sink    item,
    wsl_out_if.source result,
    wsl_cfg_if.sink   cfg
);
    import wsl_pkg::*;

    logic [TARGET_W-1:0] waypoint_count_reg;
    logic [REACH_W-1:0]  reach_distance_reg;
    logic [LIMIT_W-1:0]  max_steer_step_reg;
    logic [LIMIT_W-1:0]  max_steer_reg;
    cfg_t                cfg_bus;
    cmd_t                cmd;
    status_t             st;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waypoint_count_reg <= '0;
            reach_distance_reg <= 16'd256;
            max_steer_step_reg <= 15'd364;
            max_steer_reg      <= 15'd5461;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_WAYPOINT_COUNT: waypoint_count_reg <= cfg.data[TARGET_W-1:0];
                CFG_REACH_DISTANCE: reach_distance_reg <= cfg.data[REACH_W-1:0];
                CFG_MAX_STEER_STEP: max_steer_step_reg <= cfg.data[LIMIT_W-1:0];
                CFG_MAX_STEER:      max_steer_reg      <= cfg.data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_bus.waypoint_count = waypoint_count_reg;
    assign cfg_bus.reach_distance = reach_distance_reg;
    assign cfg_bus.max_steer_step = max_steer_step_reg;
    assign cfg_bus.max_steer      = max_steer_reg;

    wsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_opcode (item.opcode),
        .in_ready  (item.ready),
        .st        (st),
        .cmd       (cmd)
    );

    wsl_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cfg           (cfg_bus),
        .waypoint_slot (item.waypoint_slot),
        .waypoint_x    (item.waypoint_x),
        .waypoint_y    (item.waypoint_y),
        .pos_x         (item.pos_x),
        .pos_y         (item.pos_y),
        .heading       (item.heading),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .steer_angle   (result.steer_angle),
        .target_index  (result.target_index),
        .finished      (result.finished)
    );

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item accepted while another is in work");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(result.valid && !result.ready))
        else $error("pending result overwritten");

    a_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.steer |-> $past(cmd.delta))
        else $error("steer update without limited error");

endmodule

// ----- rtl/wsl_ctrl.sv -----
`timescale 1ns / 1ps

module wsl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_opcode,
    output logic             in_ready,
    input  wsl_pkg::status_t st,
    output wsl_pkg::cmd_t    cmd
);
    import wsl_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_DX;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    if (in_opcode == OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                        state_next  = S_OUT;
                    end
                    else if (st.target_done)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_SQ_X;
            end
            S_SQ_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
                state_next  = S_SQ_Y;
            end
            S_SQ_Y:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_DY;
                cmd.sum_first = 1'b1;
                state_next    = S_SQ_R;
            end
            S_SQ_R:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_R;
                cmd.sum_add = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (st.near)
                begin
                    cmd.target_inc = 1'b1;
                    state_next     = S_ADV;
                end
                else
                begin
                    state_next = S_CINIT;
                end
            end
            S_ADV:
            begin
                state_next = st.target_done ? S_OUT : S_READ2;
            end
            S_READ2:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_DIFF2;
            end
            S_DIFF2:
            begin
                cmd.diff   = 1'b1;
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                state_next      = S_CITER;
            end
            S_CITER:
            begin
                cmd.cordic_step = 1'b1;
                if (st.cordic_last)
                begin
                    state_next = S_DELTA;
                end
            end
            S_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = S_STEER;
            end
            S_STEER:
            begin
                cmd.steer  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/wsl_datapath.sv -----
`timescale 1ns / 1ps

module wsl_datapath #(
    parameter int MAX_WAYPOINTS = 256,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wsl_pkg::cmd_t                      cmd,
    output wsl_pkg::status_t                   st,
    input  wsl_pkg::cfg_t                      cfg,
    input  logic [wsl_pkg::SLOT_W-1:0]         waypoint_slot,
    input  logic signed [wsl_pkg::COORD_W-1:0] waypoint_x,
    input  logic signed [wsl_pkg::COORD_W-1:0] waypoint_y,
    input  logic signed [wsl_pkg::COORD_W-1:0] pos_x,
    input  logic signed [wsl_pkg::COORD_W-1:0] pos_y,
    input  logic signed [wsl_pkg::ANGLE_W-1:0] heading,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic signed [wsl_pkg::ANGLE_W-1:0] steer_angle,
    output logic [wsl_pkg::TARGET_W-1:0]       target_index,
    output logic                               finished
);
    import wsl_pkg::*;

    localparam int AW = (MAX_WAYPOINTS > 2) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = (AW + 1 > TARGET_W + 1) ? AW + 1 : TARGET_W + 1;
    localparam logic [CW-1:0] MAX_CW = CW'(MAX_WAYPOINTS);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

    logic signed [COORD_W-1:0] mem_x [MAX_WAYPOINTS];
    logic signed [COORD_W-1:0] mem_y [MAX_WAYPOINTS];

    logic signed [COORD_W-1:0] rd_x_reg;
    logic signed [COORD_W-1:0] rd_y_reg;
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic signed [ANGLE_W-1:0] heading_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dy_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]         d2_reg;
    logic signed [CX_W-1:0]    cx_reg;
    logic signed [CX_W-1:0]    cy_reg;
    logic [Z_W-1:0]            cz_reg;
    logic                      zero_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic signed [ANGLE_W:0]   delta_reg;
    logic [TARGET_W-1:0]       target_reg;
    logic signed [ANGLE_W-1:0] steer_reg;
    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] out_steer_reg;
    logic [TARGET_W-1:0]       out_target_reg;
    logic                      out_finished_reg;

    logic [AW+SLOT_W-1:0]      slot_wide;
    logic [AW+TARGET_W-1:0]    target_wide;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic                      slot_ok;
    logic [CW-1:0]             count_wide;
    logic [CW-1:0]             cnt_eff;
    logic                      target_done;

    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [DIFF_W-1:0]  mul_b;

    logic signed [CX_W-1:0]    x_init;
    logic signed [CX_W-1:0]    y_init;
    logic signed [CX_W-1:0]    x_sh;
    logic signed [CX_W-1:0]    y_sh;
    logic [ITER_W-1:0]         atan_idx;
    logic [Z_W-1:0]            z_round;
    logic [ANGLE_W-1:0]        bearing;
    logic [ANGLE_W-1:0]        err16;
    logic signed [ANGLE_W:0]   err;
    logic signed [ANGLE_W:0]   step_lim;
    logic signed [ANGLE_W:0]   delta_next;
    logic signed [ANGLE_W+1:0] steer_sum;
    logic signed [ANGLE_W+1:0] steer_lim;
    logic signed [ANGLE_W+1:0] steer_clamped;
    logic signed [ANGLE_W-1:0] steer_next;

    // table addressing and effective waypoint count
    assign slot_wide   = {{AW{1'b0}}, waypoint_slot};
    assign target_wide = {{AW{1'b0}}, target_reg};
    assign wr_addr     = slot_wide[AW-1:0];
    assign rd_addr     = target_wide[AW-1:0];
    assign slot_ok     = CW'(waypoint_slot) < MAX_CW;
    assign count_wide  = CW'(cfg.waypoint_count);
    assign cnt_eff     = (count_wide < MAX_CW) ? count_wide : MAX_CW;
    assign target_done = CW'(target_reg) >= cnt_eff;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && slot_ok)
        begin
            mem_x[wr_addr] <= waypoint_x;
            mem_y[wr_addr] <= waypoint_y;
        end
        if (cmd.mem_rd)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    // shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            MUL_DY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            default:
            begin
                mul_a = DIFF_W'({1'b0, cfg.reach_distance});
                mul_b = DIFF_W'({1'b0, cfg.reach_distance});
            end
        endcase
    end

    // CORDIC vectoring step
    assign x_init   = {{(CX_W-DIFF_W-16){dx_reg[DIFF_W-1]}}, dx_reg, 16'h0000};
    assign y_init   = {{(CX_W-DIFF_W-16){dy_reg[DIFF_W-1]}}, dy_reg, 16'h0000};
    assign x_sh     = cx_reg >>> iter_reg;
    assign y_sh     = cy_reg >>> iter_reg;
    assign atan_idx = iter_reg;

    // bearing error, rate limit and steer clamp
    assign z_round   = cz_reg + 32'h0000_8000;
    assign bearing   = zero_reg ? '0 : z_round[Z_W-1:Z_W-ANGLE_W];
    assign err16     = bearing - heading_reg - steer_reg;
    assign err       = {err16[ANGLE_W-1], err16};
    assign step_lim  = {2'b00, cfg.max_steer_step};
    assign steer_sum = {{2{steer_reg[ANGLE_W-1]}}, steer_reg} + {delta_reg[ANGLE_W], delta_reg};
    assign steer_lim = {3'b000, cfg.max_steer};

    always_comb
    begin
        if (err > step_lim)
        begin
            delta_next = step_lim;
        end
        else if (err < -step_lim)
        begin
            delta_next = -step_lim;
        end
        else
        begin
            delta_next = err;
        end

        if (steer_sum > steer_lim)
        begin
            steer_clamped = steer_lim;
        end
        else if (steer_sum < -steer_lim)
        begin
            steer_clamped = -steer_lim;
        end
        else
        begin
            steer_clamped = steer_sum;
        end
        steer_next = steer_clamped[ANGLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg      <= pos_x;
            py_reg      <= pos_y;
            heading_reg <= heading;
        end
        if (cmd.diff)
        begin
            dx_reg <= DIFF_W'(rd_x_reg) - DIFF_W'(px_reg);
            dy_reg <= DIFF_W'(rd_y_reg) - DIFF_W'(py_reg);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.sum_first)
        begin
            d2_reg <= $unsigned(prod_reg);
        end
        else if (cmd.sum_add)
        begin
            d2_reg <= d2_reg + $unsigned(prod_reg);
        end
        if (cmd.cordic_init)
        begin
            zero_reg <= (dx_reg == '0) && (dy_reg == '0);
            iter_reg <= '0;
            if (dx_reg[DIFF_W-1])
            begin
                cx_reg <= -x_init;
                cy_reg <= -y_init;
                cz_reg <= 32'h8000_0000;
            end
            else
            begin
                cx_reg <= x_init;
                cy_reg <= y_init;
                cz_reg <= '0;
            end
        end
        else if (cmd.cordic_step)
        begin
            iter_reg <= iter_reg + 1'b1;
            if (!cy_reg[CX_W-1])
            begin
                cx_reg <= cx_reg + y_sh;
                cy_reg <= cy_reg - x_sh;
                cz_reg <= cz_reg + atan_unit(atan_idx);
            end
            else
            begin
                cx_reg <= cx_reg - y_sh;
                cy_reg <= cy_reg + x_sh;
                cz_reg <= cz_reg - atan_unit(atan_idx);
            end
        end
        if (cmd.delta)
        begin
            delta_reg <= delta_next;
        end
        if (cmd.out_load)
        begin
            out_steer_reg    <= steer_reg;
            out_target_reg   <= target_reg;
            out_finished_reg <= target_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            steer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.target_inc)
            begin
                target_reg <= target_reg + 1'b1;
            end
            if (cmd.steer)
            begin
                steer_reg <= steer_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.target_done = target_done;
    assign st.near        = d2_reg < $unsigned(prod_reg);
    assign st.cordic_last = iter_reg == LAST_ITER;
    assign st.out_busy    = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign steer_angle  = out_steer_reg;
    assign target_index = out_target_reg;
    assign finished     = out_finished_reg;

endmodule
